>>> rtl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

  // pattern and window geometry
  localparam int MAX_PATTERN = 16;
  localparam int HIST_DEPTH  = MAX_PATTERN;
  localparam int WIN_DEPTH   = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
  localparam int PAT_W       = 8 * MAX_PATTERN;
  localparam int ADDR_W      = 32;

  // result queue
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ASCII_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR    = 3'd4;

  localparam logic [7:0] SLASH = 8'h2F;

  // one reported match
  typedef struct packed {
    logic [ADDR_W-1:0] match_address;
    logic              last_result;
  } res_t;

  // results caused by one accepted byte, packed from the first slot
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_pair_t;

endpackage

`default_nettype wire

>>> rtl/bpm_match.sv
`default_nettype none

module bpm_match (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          req_accept,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          last_byte,
  input  wire logic [bpm_pkg::PAT_W-1:0]     pattern,
  input  wire logic [bpm_pkg::LEN_W-1:0]     pattern_length,
  input  wire logic                          ascii_mode,
  input  wire logic [bpm_pkg::ADDR_W-1:0]    base_address,
  output bpm_pkg::res_pair_t                 results
);

  logic [7:0]                  hist_r [bpm_pkg::HIST_DEPTH];
  logic [31:0]                 seen_r, seen_nxt;
  logic                        pend_r, pend_nxt;
  logic [bpm_pkg::ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;

  logic [7:0]                  win [bpm_pkg::WIN_DEPTH];
  logic [bpm_pkg::LEN_W-1:0]   len;
  logic [31:0]                 seen_inc;
  logic                        hit;
  logic                        before_slash;
  logic                        pend_ok;
  logic                        match_out;
  logic                        match_hold;
  logic [bpm_pkg::ADDR_W-1:0]  addr;
  logic [bpm_pkg::WIN_IDX_W-1:0] idx;

  // clamp the configured length into 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len = bpm_pkg::LEN_W'(1);
    end else if (pattern_length > bpm_pkg::LEN_W'(bpm_pkg::MAX_PATTERN)) begin
      len = bpm_pkg::LEN_W'(bpm_pkg::MAX_PATTERN);
    end else begin
      len = pattern_length;
    end
  end

  // window: newest byte first, then the stored history
  always_comb begin
    win[0] = data_byte;
    for (int i = 1; i < bpm_pkg::WIN_DEPTH; i++) begin
      win[i] = hist_r[i-1];
    end
  end

  // saturating byte count including the new byte
  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + 32'd1;

  // parallel compare of every pattern byte against its window slot
  always_comb begin
    hit = (seen_inc >= 32'(len));
    idx = '0;
    for (int k = 0; k < bpm_pkg::MAX_PATTERN; k++) begin
      idx = bpm_pkg::WIN_IDX_W'(len) - bpm_pkg::WIN_IDX_W'(k) - bpm_pkg::WIN_IDX_W'(1);
      if (bpm_pkg::LEN_W'(k) < len) begin
        if (win[idx] != pattern[8*k +: 8]) begin
          hit = 1'b0;
        end
      end
    end
  end

  // byte just before the match, only when it belongs to the stream
  assign before_slash = (seen_inc > 32'(len)) &&
                        (win[bpm_pkg::WIN_IDX_W'(len)] == bpm_pkg::SLASH);

  assign addr    = base_address + (seen_inc - 32'(len));
  assign pend_ok = pend_r && (data_byte != bpm_pkg::SLASH);

  // ascii mode holds a match for its lookahead unless the range ends here
  always_comb begin
    match_out  = 1'b0;
    match_hold = 1'b0;
    if (hit) begin
      if (ascii_mode) begin
        if (!before_slash) begin
          match_out  = last_byte;
          match_hold = !last_byte;
        end
      end else begin
        match_out = 1'b1;
      end
    end
  end

  // result slots in model order: confirmed pending match first
  always_comb begin
    results.count                = 2'(pend_ok) + 2'(match_out);
    results.first.match_address  = pend_ok ? pend_addr_r : addr;
    results.first.last_result    = !(pend_ok && match_out);
    results.second.match_address = addr;
    results.second.last_result   = 1'b1;
  end

  // next state of the stream tracking
  always_comb begin
    seen_nxt      = seen_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    if (req_accept) begin
      seen_nxt = last_byte ? 32'd0 : seen_inc;
      pend_nxt = match_hold;
      if (match_hold) begin
        pend_addr_nxt = addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      pend_r      <= 1'b0;
      pend_addr_r <= '0;
    end else begin
      seen_r      <= seen_nxt;
      pend_r      <= pend_nxt;
      pend_addr_r <= pend_addr_nxt;
    end
  end

  // byte history shift line
  always_ff @(posedge clk) begin
    if (req_accept) begin
      hist_r[0] <= data_byte;
      for (int i = 1; i < bpm_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpm_res_fifo.sv
`default_nettype none

module bpm_res_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire bpm_pkg::res_pair_t push_data,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bpm_pkg::res_t           out_data
);

  bpm_pkg::res_t                   mem_r [bpm_pkg::FIFO_DEPTH];
  logic [bpm_pkg::FIFO_PTR_W-1:0]  wr_r, wr_nxt;
  logic [bpm_pkg::FIFO_PTR_W-1:0]  rd_r, rd_nxt;
  logic [bpm_pkg::FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bpm_pkg::FIFO_CNT_W-1:0]  push_n;
  logic                            pop;

  // room for a full pair regardless of the output side
  assign room      = (cnt_r <= bpm_pkg::FIFO_CNT_W'(bpm_pkg::FIFO_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign push_n    = push ? bpm_pkg::FIFO_CNT_W'(push_data.count) : '0;

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r + bpm_pkg::FIFO_PTR_W'(push_n);
    rd_nxt  = rd_r + bpm_pkg::FIFO_PTR_W'(pop);
    cnt_nxt = cnt_r + push_n - bpm_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // write up to two entries per request
  always_ff @(posedge clk) begin
    if (push && push_data.count != 2'd0) begin
      mem_r[wr_r] <= push_data.first;
    end
    if (push && push_data.count == 2'd2) begin
      mem_r[wr_r + bpm_pkg::FIFO_PTR_W'(1)] <= push_data.second;
    end
  end

endmodule

`default_nettype wire

>>> rtl/byte_pattern_matcher.sv
`default_nettype none

// Byte pattern matcher: memory bytes stream in on the in_ channel, one per request,
// tlast marking the final byte of a range. Each byte is compared in parallel against
// the configured 1 to 16 byte pattern, and every match start address (base plus offset)
// leaves on the out_ channel, tlast marking the last result caused by that byte. The
// block accepts one byte per cycle; a byte may cause up to two results, and the four
// entry result queue drains at most one per cycle, so in_tready drops while fewer than
// two entries are free. In ASCII mode a match is held back by one byte to check that
// the following byte is not a slash. Write configuration only while the block is idle.
module byte_pattern_matcher (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [63:0]                     cfg_data,
  // input bytes
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  wire logic                            in_tlast,   // last_byte
  // match results
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [31:0]                          out_tdata,  // [31:0] match_address
  output logic                                 out_tlast   // last_result
);

  logic [63:0]                  pat_lo_r, pat_lo_nxt;
  logic [63:0]                  pat_hi_r, pat_hi_nxt;
  logic [bpm_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic                         ascii_r, ascii_nxt;
  logic [bpm_pkg::ADDR_W-1:0]   base_r, base_nxt;
  logic                         cfg_we;
  logic                         in_accept;
  logic                         room;
  bpm_pkg::res_pair_t           results;
  bpm_pkg::res_t                head;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_tready = room;
  assign in_accept = in_tvalid && in_tready;

  // configuration register writes
  always_comb begin
    pat_lo_nxt = pat_lo_r;
    pat_hi_nxt = pat_hi_r;
    len_nxt    = len_r;
    ascii_nxt  = ascii_r;
    base_nxt   = base_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bpm_pkg::REG_PATTERN_LOW:  pat_lo_nxt = cfg_data;
        bpm_pkg::REG_PATTERN_HIGH: pat_hi_nxt = cfg_data;
        bpm_pkg::REG_PATTERN_LEN:  len_nxt    = cfg_data[bpm_pkg::LEN_W-1:0];
        bpm_pkg::REG_ASCII_MODE:   ascii_nxt  = cfg_data[0];
        bpm_pkg::REG_BASE_ADDR:    base_nxt   = cfg_data[bpm_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      len_r    <= bpm_pkg::LEN_W'(1);
      ascii_r  <= 1'b0;
      base_r   <= '0;
    end else begin
      pat_lo_r <= pat_lo_nxt;
      pat_hi_r <= pat_hi_nxt;
      len_r    <= len_nxt;
      ascii_r  <= ascii_nxt;
      base_r   <= base_nxt;
    end
  end

  // window compare and stream tracking
  bpm_match u_match (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_accept     (in_accept),
    .data_byte      (in_tdata),
    .last_byte      (in_tlast),
    .pattern        ({pat_hi_r, pat_lo_r}),
    .pattern_length (len_r),
    .ascii_mode     (ascii_r),
    .base_address   (base_r),
    .results        (results)
  );

  // result queue toward the output channel
  bpm_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (results),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign out_tdata = head.match_address;
  assign out_tlast = head.last_result;

endmodule

`default_nettype wire
